### rtl/adnt_pkg.sv
// Shared constants, types and the power-of-ten table of the decimal tokenizer.
`default_nettype none

package adnt_pkg;

  localparam int MAG_BITS        = 32;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 9;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 8;
  localparam int VALUE_W = 49;
  localparam int FD_W    = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int QUO_W   = MAG_BITS + FRAC_BITS;
  localparam int CNT_W   = $clog2(QUO_W);

  localparam logic [FIELD_W-1:0] FIELD_MAX       = '1;
  localparam logic [FIELD_W-1:0] EXPECTED_RESET  = FIELD_W'(7);
  localparam logic [VALUE_W-1:0] VALUE_LIMIT     = {1'b0, {(VALUE_W-1){1'b1}}};

  localparam logic [BYTE_W-1:0] CH_NEWLINE = BYTE_W'(10);
  localparam logic [BYTE_W-1:0] CH_MINUS   = BYTE_W'(45);
  localparam logic [BYTE_W-1:0] CH_POINT   = BYTE_W'(46);
  localparam logic [BYTE_W-1:0] CH_ZERO    = BYTE_W'(48);
  localparam logic [BYTE_W-1:0] CH_NINE    = BYTE_W'(57);

  localparam logic KIND_NUMBER  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  function automatic logic [63:0] pow10(input logic [3:0] n);
    logic [63:0] p;
    unique case (n)
      4'd0:  p = 64'd1;
      4'd1:  p = 64'd10;
      4'd2:  p = 64'd100;
      4'd3:  p = 64'd1000;
      4'd4:  p = 64'd10000;
      4'd5:  p = 64'd100000;
      4'd6:  p = 64'd1000000;
      4'd7:  p = 64'd10000000;
      4'd8:  p = 64'd100000000;
      4'd9:  p = 64'd1000000000;
      4'd10: p = 64'd10000000000;
      4'd11: p = 64'd100000000000;
      4'd12: p = 64'd1000000000000;
      4'd13: p = 64'd10000000000000;
      4'd14: p = 64'd100000000000000;
      4'd15: p = 64'd1000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

  localparam logic [63:0] MAX_DIVISOR = pow10(4'(MAX_FRAC_DIGITS));
  localparam int          DIV_W       = $clog2(MAX_DIVISOR + 64'd1);

  typedef struct packed {
    logic                has_num;
    logic                has_sum;
    logic [MAG_BITS-1:0] magnitude;
    logic [FD_W-1:0]     frac_digits;
    logic                negative;
    logic                token_ovf;
    logic [FIELD_W-1:0]  field_index;
    logic [FIELD_W-1:0]  field_count;
    logic                line_ok;
  } tok_job_t;

  typedef struct packed {
    logic     valid;
    tok_job_t job;
  } job_push_t;

  typedef struct packed {
    logic     valid;
    tok_job_t job;
  } job_head_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_RND,
    BK_NUM,
    BK_SUM
  } back_state_t;

endpackage

`default_nettype wire

### rtl/adnt_if.sv
// Handshake interfaces for the character, result and configuration channels.
`default_nettype none

interface adnt_char_if
  import adnt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_data;

  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink (input valid, data_byte, end_of_data, output ready);
endinterface

interface adnt_result_if
  import adnt_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [VALUE_W-1:0] value;
  logic [FIELD_W-1:0]        field_index;
  logic [FIELD_W-1:0]        field_count;
  logic                      line_ok;
  logic                      overflow;
  logic                      last;

  modport source (output valid, kind, value, field_index, field_count, line_ok, overflow, last,
                  input ready);
  modport sink (input valid, kind, value, field_index, field_count, line_ok, overflow, last,
                output ready);
endinterface

interface adnt_cfg_if
  import adnt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] expected_fields;

  modport source (output valid, expected_fields, input ready);
  modport sink (input valid, expected_fields, output ready);
endinterface

`default_nettype wire

### rtl/adnt_front.sv
// Front end: classifies bytes, accumulates the token and queues number and line jobs.
`default_nettype none

module adnt_front
  import adnt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  adnt_char_if.sink  char_in,
  adnt_cfg_if.sink   cfg,
  input  wire logic  push_ready,
  output job_push_t  push
);

  logic [MAG_BITS-1:0] magnitude, magnitude_next;
  logic                negative, negative_next;
  logic                in_fraction, in_fraction_next;
  logic [FD_W-1:0]     fraction_digits, fraction_digits_next;
  logic                reading_digits, reading_digits_next;
  logic                token_overflow, token_overflow_next;
  logic [FIELD_W-1:0]  line_fields, line_fields_next;
  logic [FIELD_W-1:0]  expected_fields;

  logic                  accept;
  logic                  is_minus, is_digit, is_point, is_other;
  logic                  flush, line_end, emit;
  logic [3:0]            digit;
  logic [MAG_BITS+3:0]   scaled;
  logic [FIELD_W-1:0]    fields_inc, fields_after;

  assign char_in.ready = push_ready;
  assign cfg.ready     = 1'b1;
  assign accept        = char_in.valid & char_in.ready;

  always_comb begin
    is_minus = char_in.data_byte == CH_MINUS;
    is_point = char_in.data_byte == CH_POINT;
    is_digit = (char_in.data_byte >= CH_ZERO) && (char_in.data_byte <= CH_NINE);
    is_other = !(is_minus || is_point || is_digit);
    digit    = 4'(char_in.data_byte - CH_ZERO);
    scaled   = {4'b0, magnitude} * (MAG_BITS+4)'(10) + (MAG_BITS+4)'(digit);

    magnitude_next       = magnitude;
    negative_next        = negative;
    in_fraction_next     = in_fraction;
    fraction_digits_next = fraction_digits;
    reading_digits_next  = reading_digits;
    token_overflow_next  = token_overflow;

    if (is_minus) begin
      negative_next = 1'b1;
    end else if (is_point) begin
      in_fraction_next = 1'b1;
    end else if (is_digit) begin
      reading_digits_next = 1'b1;
      if (in_fraction && (fraction_digits >= FD_W'(MAX_FRAC_DIGITS))) begin
        token_overflow_next = 1'b1;
      end else begin
        if (scaled[MAG_BITS+3:MAG_BITS] != 4'b0) begin
          magnitude_next      = '1;
          token_overflow_next = 1'b1;
        end else begin
          magnitude_next = scaled[MAG_BITS-1:0];
        end
        if (in_fraction) begin
          fraction_digits_next = fraction_digits + FD_W'(1);
        end
      end
    end

    flush        = is_other || char_in.end_of_data;
    line_end     = (is_other && (char_in.data_byte == CH_NEWLINE)) || char_in.end_of_data;
    emit         = flush && reading_digits_next;
    fields_inc   = (line_fields == FIELD_MAX) ? FIELD_MAX : line_fields + FIELD_W'(1);
    fields_after = emit ? fields_inc : line_fields;

    push.valid            = accept && (emit || line_end);
    push.job.has_num      = emit;
    push.job.has_sum      = line_end;
    push.job.magnitude    = magnitude_next;
    push.job.frac_digits  = fraction_digits_next;
    push.job.negative     = negative_next;
    push.job.token_ovf    = token_overflow_next;
    push.job.field_index  = line_fields;
    push.job.field_count  = fields_after;
    push.job.line_ok      = fields_after == expected_fields;

    line_fields_next = line_end ? '0 : fields_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude       <= '0;
      negative        <= 1'b0;
      in_fraction     <= 1'b0;
      fraction_digits <= '0;
      reading_digits  <= 1'b0;
      token_overflow  <= 1'b0;
      line_fields     <= '0;
    end else if (accept) begin
      line_fields <= line_fields_next;
      if (flush) begin
        magnitude       <= '0;
        negative        <= 1'b0;
        in_fraction     <= 1'b0;
        fraction_digits <= '0;
        reading_digits  <= 1'b0;
        token_overflow  <= 1'b0;
      end else begin
        magnitude       <= magnitude_next;
        negative        <= negative_next;
        in_fraction     <= in_fraction_next;
        fraction_digits <= fraction_digits_next;
        reading_digits  <= reading_digits_next;
        token_overflow  <= token_overflow_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_fields <= EXPECTED_RESET;
    end else if (cfg.valid && cfg.ready) begin
      expected_fields <= cfg.expected_fields;
    end
  end

endmodule

`default_nettype wire

### rtl/adnt_queue.sv
// Two-entry job queue between the front end and the conversion back end.
`default_nettype none

module adnt_queue
  import adnt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire job_push_t push,
  output logic           push_ready,
  output job_head_t      head,
  input  wire logic      pop
);

  tok_job_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = count != 2'd2;
  assign head.valid = count != 2'd0;
  assign head.job   = mem[rd_ptr];
  assign do_push    = push.valid;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> push_ready)
    else $error("Job pushed into a full queue.");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("Queue count out of range.");

endmodule

`default_nettype wire

### rtl/adnt_back.sv
// Back end: bit-serial fixed-point conversion of numbers and result delivery.
`default_nettype none

module adnt_back
  import adnt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire job_head_t head,
  output logic           pop,
  adnt_result_if.source  result
);

  back_state_t state, state_next;

  tok_job_t           job;
  logic [QUO_W-1:0]   quo;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   divisor;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] value;
  logic               ovf;

  logic [DIV_W:0]     shifted;
  logic               ge;
  logic [DIV_W:0]     diff;
  logic               round_up;
  logic [VALUE_W-1:0] rounded;
  logic               sat;
  logic [VALUE_W-1:0] mag_val;

  always_comb begin
    shifted  = {rem, quo[QUO_W-1]};
    ge       = shifted >= {1'b0, divisor};
    diff     = shifted - {1'b0, divisor};
    round_up = {rem, 1'b0} >= {1'b0, divisor};
    rounded  = {{(VALUE_W-QUO_W){1'b0}}, quo} + VALUE_W'(round_up);
    sat      = rounded > VALUE_LIMIT;
    mag_val  = sat ? VALUE_LIMIT : rounded;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = head.job.has_num ? BK_DIV : BK_SUM;
        end
      end
      BK_DIV: begin
        if (cnt == '0) begin
          state_next = BK_RND;
        end
      end
      BK_RND: begin
        state_next = BK_NUM;
      end
      BK_NUM: begin
        if (result.ready) begin
          state_next = job.has_sum ? BK_SUM : BK_IDLE;
        end
      end
      BK_SUM: begin
        if (result.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        job     <= head.job;
        quo     <= {head.job.magnitude, {FRAC_BITS{1'b0}}};
        rem     <= '0;
        divisor <= DIV_W'(pow10(4'(head.job.frac_digits)));
        cnt     <= CNT_W'(QUO_W - 1);
      end
      BK_DIV: begin
        quo <= {quo[QUO_W-2:0], ge};
        rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        cnt <= cnt - CNT_W'(1);
      end
      BK_RND: begin
        value <= job.negative ? VALUE_W'(0) - mag_val : mag_val;
        ovf   <= job.token_ovf || sat;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.valid       = (state == BK_NUM) || (state == BK_SUM);
    result.kind        = (state == BK_SUM) ? KIND_SUMMARY : KIND_NUMBER;
    result.value       = (state == BK_SUM) ? '0 : value;
    result.field_index = (state == BK_SUM) ? '0 : job.field_index;
    result.field_count = (state == BK_SUM) ? job.field_count : '0;
    result.line_ok     = (state == BK_SUM) ? job.line_ok : 1'b0;
    result.overflow    = (state == BK_SUM) ? 1'b0 : ovf;
    result.last        = (state == BK_SUM) ? 1'b1 : !job.has_sum;
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) |-> (rem < divisor))
    else $error("Division remainder reached the divisor.");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) && (cnt == '0) |=> (state == BK_RND))
    else $error("Division did not finish after the last quotient bit.");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.kind == KIND_SUMMARY) |-> result.last)
    else $error("Line summary not marked as the final result.");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == BK_IDLE) && head.valid)
    else $error("Job taken while the back end was busy.");

endmodule

`default_nettype wire

### rtl/ascii_decimal_number_tokenizer_core.sv
// Top level of the ASCII decimal number tokenizer.
`default_nettype none

// Parses a text stream one byte per transfer into signed fixed-point numbers (16 fraction
// bits, rounded half away from zero) and per-line summaries. The front end takes one byte
// per cycle as long as its two-entry job queue has room; while the queue is full every byte
// waits, including bytes that produce no result. Each number is converted by a restoring
// divider that yields one quotient bit per cycle and is then rounded, so a number holds the back
// end from its division through its result transfers; a summary alone holds it for its
// transfer. The configuration register expected_fields resets to 7 and may be written at
// any time the block is idle.
module ascii_decimal_number_tokenizer_core
  import adnt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  adnt_char_if.sink     char_in,
  adnt_cfg_if.sink      cfg,
  adnt_result_if.source result
);

  job_push_t push;
  job_head_t head;
  logic      push_ready;
  logic      pop;

  adnt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push       (push)
  );

  adnt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  adnt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire
